>>> rtl/rpe_pkg.sv
// Shared widths and constants of the periodic repulsive pair energy unit.
// No dependencies; used by every module of the block.
package rpe_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned DistW    = 49;
  localparam int unsigned MulBW    = 48;
  localparam int unsigned ProdW    = DistW + MulBW;
  localparam int unsigned RecW     = 48;
  localparam int unsigned DenW     = 57;
  localparam int unsigned EnergyW  = 63;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_LENGTH   = 2'd0,
    REG_CUT_SQ       = 2'd1,
    REG_INV_SIGMA_SQ = 2'd2,
    REG_FOUR_EPSILON = 2'd3
  } cfg_reg_e;

  localparam logic [EnergyW-1:0] EnergyMax = {EnergyW{1'b1}};
  localparam logic [DenW-1:0]    DenMin    = DenW'(17'h10000);

endpackage

>>> rtl/rpe_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rpe_pkg.
module rpe_mul
  import rpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DistW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(MulBW);

  logic [DistW-1:0] a_q;
  logic [ProdW-1:0] prod_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DistW:0]   sum;

  assign sum = {1'b0, prod_q[ProdW-1:MulBW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q    <= a_i;
      prod_q <= {{DistW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[MulBW-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

>>> rtl/rpe_div.sv
// Restoring divider forming floor(2^64 / den), one quotient bit per cycle.
// Depends on rpe_pkg.
module rpe_div
  import rpe_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [RecW-1:0] quo_o
);

  localparam int unsigned Steps = 65;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [DenW-1:0] den_q, rem_q;
  logic [RecW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, (cnt_q == '0)};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_q <= {quo_q[RecW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/periodic_repulsive_pair_energy_unit.sv
// Top level of the periodic repulsive pair energy unit: sequencer, accumulator, ports.
// Depends on rpe_pkg, rpe_mul and rpe_div.
//
// Channel  Direction  Handshake               Payload
// s_axis   in         s_axis_tvalid/tready    pair coordinates and indices, tlast
// m_axis   out        m_axis_tvalid/tready    energy total, tuser saturation flag
// cfg      in         cfg_valid_i/cfg_ready_o register index and data
//
// A pair runs eight 48-step serial multiplies and one 65-step division one after another
// before the next request is taken. A self pair skips all of them, and a pair at or beyond
// the cutoff or with zero epsilon skips all but the two squaring multiplies.
// An overflow ends the pair early.
// Reset clears the running sum, the flag and all handshake state.
// A last pair waits while an earlier total has not yet been taken.
module periodic_repulsive_pair_energy_unit
  import rpe_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, neighbor_x, neighbor_y, center_index, neighbor_index
  input  logic [((4*CoordW+2*INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // energy_total
  output logic [63:0]           m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRAP, ST_SQX, ST_SQY, ST_CUT, ST_MU, ST_DIV,
    ST_R2, ST_R4, ST_R6, ST_R12, ST_TERM, ST_ADD, ST_FIN
  } state_e;

  state_e                 state_q;
  logic [CoordW-1:0]      box_q, cx_q, cy_q, nx_q, ny_q, ay_q;
  logic [CfgDataW-1:0]    cut_q;
  logic [31:0]            inv_q, fe_q;
  logic                   self_q, last_q;
  logic [DistW-1:0]       d2_q;
  logic [RecW-1:0]        r2_q;
  logic [EnergyW-1:0]     term_q, sum_q;
  logic                   ovf_q, sat_q;
  logic                   m_valid_q, m_sat_q;
  logic [EnergyW-1:0]     m_energy_q;
  logic                   mul_start_q, div_start_q;
  logic [DistW-1:0]       mul_a_q;
  logic [MulBW-1:0]       mul_b_q;
  logic [DenW-1:0]        den_q;

  logic                   mul_busy, mul_done, div_busy, div_done;
  logic [ProdW-1:0]       prod;
  logic [RecW-1:0]        quo;
  logic signed [CoordW+1:0] dx, dy, wx, wy;
  logic [CoordW-1:0]      axw, ayw;
  logic                   prod_ovf;
  logic [RecW-1:0]        prod_q32;
  logic [DenW-1:0]        u_val;
  logic [EnergyW:0]       sum_ext;
  logic                   skip_pair, emit, mul_start_d, div_start_d;

  function automatic logic signed [CoordW+1:0] wrap_d(logic signed [CoordW+1:0] d,
                                                      logic [CoordW-1:0] len);
    logic signed [CoordW+2:0] d2x, l;
    logic signed [CoordW+1:0] res;
    d2x = {d, 1'b0};
    l   = {3'b000, len};
    res = d;
    if (d2x > l) res = d - {2'b00, len};
    else if (d2x < -l) res = d + {2'b00, len};
    return res;
  endfunction

  assign dx  = {2'b00, nx_q} - {2'b00, cx_q};
  assign dy  = {2'b00, ny_q} - {2'b00, cy_q};
  assign wx  = wrap_d(dx, box_q);
  assign wy  = wrap_d(dy, box_q);
  assign axw = wx[CoordW+1] ? CoordW'(-wx) : wx[CoordW-1:0];
  assign ayw = wy[CoordW+1] ? CoordW'(-wy) : wy[CoordW-1:0];

  assign prod_ovf = prod[ProdW-1:80] != '0;
  assign prod_q32 = prod[79:32];
  assign u_val    = prod[80:24];
  assign sum_ext  = {1'b0, sum_q} + {1'b0, term_q};

  assign skip_pair = d2_q >= {1'b0, cut_q} || fe_q == '0;
  assign emit      = state_q == ST_FIN && last_q && (!m_valid_q || m_axis_tready);

  assign mul_start_d = (state_q == ST_WRAP && !self_q) ||
                       (state_q == ST_SQX && mul_done) ||
                       (state_q == ST_CUT && !skip_pair) ||
                       (state_q == ST_DIV && div_done) ||
                       ((state_q == ST_R2 || state_q == ST_R4 || state_q == ST_R6 ||
                         state_q == ST_R12) && mul_done && !prod_ovf);
  assign div_start_d = state_q == ST_MU && mul_done && u_val > DenMin;

  rpe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  rpe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      box_q       <= CoordW'(3932160);
      cut_q       <= CfgDataW'(64'd4294967296);
      inv_q       <= 32'd16777216;
      fe_q        <= 32'd262144;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      m_sat_q     <= 1'b0;
      m_energy_q  <= '0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      if (emit) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_BOX_LENGTH:   box_q <= cfg_data_i[CoordW-1:0];
          REG_CUT_SQ:       cut_q <= cfg_data_i;
          REG_INV_SIGMA_SQ: inv_q <= cfg_data_i[31:0];
          REG_FOUR_EPSILON: fe_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      unique case (state_q) inside
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cx_q    <= s_axis_tdata[CoordW-1:0];
            cy_q    <= s_axis_tdata[2*CoordW-1:CoordW];
            nx_q    <= s_axis_tdata[3*CoordW-1:2*CoordW];
            ny_q    <= s_axis_tdata[4*CoordW-1:3*CoordW];
            self_q  <= s_axis_tdata[4*CoordW +: INDEX_WIDTH] ==
                       s_axis_tdata[4*CoordW+INDEX_WIDTH +: INDEX_WIDTH];
            last_q  <= s_axis_tlast;
            state_q <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          ay_q <= ayw;
          if (self_q) begin
            state_q <= ST_FIN;
          end else begin
            mul_a_q     <= DistW'(axw);
            mul_b_q     <= MulBW'(axw);
            state_q     <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (mul_done) begin
            d2_q        <= prod[DistW-1:0];
            mul_a_q     <= DistW'(ay_q);
            mul_b_q     <= MulBW'(ay_q);
            state_q     <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (mul_done) begin
            d2_q    <= d2_q + prod[DistW-1:0];
            state_q <= ST_CUT;
          end
        end
        ST_CUT: begin
          if (skip_pair) begin
            state_q <= ST_FIN;
          end else begin
            mul_a_q     <= d2_q;
            mul_b_q     <= MulBW'(inv_q);
            state_q     <= ST_MU;
          end
        end
        ST_MU: begin
          if (mul_done) begin
            if (u_val <= DenMin) begin
              term_q  <= EnergyMax;
              ovf_q   <= 1'b1;
              state_q <= ST_ADD;
            end else begin
              den_q       <= u_val;
              state_q     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mul_a_q     <= DistW'(quo);
            mul_b_q     <= quo;
            state_q     <= ST_R2;
          end
        end
        ST_R2, ST_R4, ST_R6, ST_R12: begin
          if (mul_done) begin
            if (prod_ovf) begin
              term_q  <= EnergyMax;
              ovf_q   <= 1'b1;
              state_q <= ST_ADD;
            end else begin
              if (state_q == ST_R2) begin
                r2_q    <= prod_q32;
                mul_a_q <= DistW'(prod_q32);
                mul_b_q <= prod_q32;
                state_q <= ST_R4;
              end else if (state_q == ST_R4) begin
                mul_a_q <= DistW'(prod_q32);
                mul_b_q <= r2_q;
                state_q <= ST_R6;
              end else if (state_q == ST_R6) begin
                mul_a_q <= DistW'(prod_q32);
                mul_b_q <= prod_q32;
                state_q <= ST_R12;
              end else begin
                mul_a_q <= DistW'(prod_q32);
                mul_b_q <= MulBW'(fe_q);
                state_q <= ST_TERM;
              end
            end
          end
        end
        ST_TERM: begin
          if (mul_done) begin
            term_q  <= EnergyW'(prod[79:24]);
            ovf_q   <= 1'b0;
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (sum_ext[EnergyW]) begin
            sum_q <= EnergyMax;
            sat_q <= 1'b1;
          end else begin
            sum_q <= sum_ext[EnergyW-1:0];
            if (ovf_q) sat_q <= 1'b1;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (emit) begin
            m_energy_q <= sum_q;
            m_sat_q    <= sat_q;
            sum_q      <= '0;
            sat_q      <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_energy_q};
  assign m_axis_tuser  = m_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mul_busy && !div_busy)
    else $error("arithmetic unit busy while sequencer idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(last_q) && $past(state_q) == ST_FIN)
    else $error("result raised outside a last pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

endmodule
